@@ sv/pcmn_pkg.sv @@
// Package for the PCM normalizer: rate constants, register map, shared types.
// Used by every module of the block; no dependencies of its own.
package pcmn_pkg;

    // Output rate and accumulator sizing
    localparam int TARGET_RATE = 44100;
    localparam int MIN_RATE    = 1400;
    localparam int MAX_RESULTS = 32;
    localparam int ACC_W       = $clog2(2 * TARGET_RATE);
    localparam int RATE_W      = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // 8-bit sample scaling
    localparam int ZERO_CODE_8   = 128;
    localparam int SCALE_DIV_8   = 127;
    localparam int FULL_SCALE_16 = 32767;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_WIDTH_MODE = 2'd0,
        REG_CHANNELS   = 2'd1,
        REG_SRC_RATE   = 2'd2
    } reg_idx_t;

    localparam logic MODE_U8 = 1'b0;
    localparam logic [1:0] CH_MONO = 2'd1;

    typedef struct packed {
        logic              width_mode;
        logic [1:0]        channel_count;
        logic [RATE_W-1:0] source_rate;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               eos;
    } frame_t;

endpackage

@@ sv/pcm_normalize_to_stereo16_44k_top.sv @@
// PCM normalizer to 16-bit stereo at 44100 Hz. Each accepted frame (8-bit
// unsigned or 16-bit signed, mono or stereo) is converted and then repeated
// by a zero-order hold: it yields between 1 and 32 output samples, about
// 44100/source_rate of them, with last_of_run marking the final one. The
// output side emits one sample per cycle unless m_ready stalls it, and holds
// each frame in the rate converter until its run is done (six or so outputs at
// 8 kHz, one at 44.1 kHz); that accumulator step sets the throughput. The input
// side takes a frame per cycle while the four-entry frame queue has room.
// Registers (APB, 4-byte stride): 0 sample width mode, 1 channel count,
// 2 source rate. Write them only while the block is idle.
module pcm_normalize_to_stereo16_44k_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcmn_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcmn_pkg::DATA_W-1:0]  pwdata,
    output logic [pcmn_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [15:0]                  s_left_raw,
    input  logic [15:0]                  s_right_raw,
    input  logic                         s_end_of_stream,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [15:0]           m_out_left,
    output logic signed [15:0]           m_out_right,
    output logic                         m_last_of_run
);
    import pcmn_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;
    logic     push_valid;
    logic     push_ready;
    frame_t   push_frame;
    logic     pop_valid;
    logic     pop_ready;
    frame_t   pop_frame;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; unknown addresses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_mode    <= 1'b1;
            cfg_reg.channel_count <= 2'd2;
            cfg_reg.source_rate   <= RATE_W'(TARGET_RATE);
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH_MODE: cfg_reg.width_mode    <= pwdata[0];
                REG_CHANNELS:   cfg_reg.channel_count <= pwdata[1:0];
                REG_SRC_RATE:   cfg_reg.source_rate   <= pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            REG_WIDTH_MODE: prdata = DATA_W'(cfg_reg.width_mode);
            REG_CHANNELS:   prdata = DATA_W'(cfg_reg.channel_count);
            REG_SRC_RATE:   prdata = DATA_W'(cfg_reg.source_rate);
            default:        prdata = '0;
        endcase
    end

    pcmn_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_raw      (s_left_raw),
        .s_right_raw     (s_right_raw),
        .s_end_of_stream (s_end_of_stream),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_frame      (push_frame)
    );

    pcmn_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    pcmn_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_frame     (pop_frame),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_left    (m_out_left),
        .m_out_right   (m_out_right),
        .m_last_of_run (m_last_of_run)
    );

    // An accepted request is held by the front end in the next cycle
    a_front_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> push_valid)
        else $error("accepted frame not held by front end");

    // Retiring a queued frame always presents the end of its run
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_valid && pop_ready |=> m_valid && m_last_of_run)
        else $error("frame retired without last_of_run output");

    // A new output appears only from a queued frame
    a_out_from_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pop_valid))
        else $error("output appeared with empty queue");

endmodule

@@ sv/pcmn_front.sv @@
// Front end: accepts input frames, converts samples to signed 16-bit stereo.
// Depends on pcmn_pkg; feeds the frame queue.
module pcmn_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  pcmn_pkg::cfg_t  cfg,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [15:0]     s_left_raw,
    input  logic [15:0]     s_right_raw,
    input  logic            s_end_of_stream,
    output logic            push_valid,
    input  logic            push_ready,
    output pcmn_pkg::frame_t push_frame
);
    import pcmn_pkg::*;

    localparam int SCALE_Q = FULL_SCALE_16 / SCALE_DIV_8;

    // Map one raw sample; 8-bit: v*32767/127 = v*258 + v/127 (remainder is one)
    function automatic logic signed [15:0] convert(input logic [15:0] raw,
                                                   input logic mode);
        logic signed [8:0]  v;
        logic signed [17:0] p;
        v = $signed({1'b0, raw[7:0]}) - 9'(ZERO_CODE_8);
        p = 18'(v) * 18'(SCALE_Q);
        if (v >= 9'(SCALE_DIV_8)) begin
            p = p + 18'sd1;
        end else if (v <= -9'(SCALE_DIV_8)) begin
            p = p - 18'sd1;
        end
        if (mode != MODE_U8) begin
            convert = $signed(raw);
        end else if (p < -18'sd32768) begin
            convert = -16'sd32768;
        end else begin
            convert = 16'(p);
        end
    endfunction

    logic   hold_valid_reg;
    frame_t hold_frame_reg;
    logic signed [15:0] left_conv;

    assign left_conv  = convert(s_left_raw, cfg.width_mode);
    assign s_ready    = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_frame = hold_frame_reg;

    // Hold the converted frame until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_frame_reg.left  <= left_conv;
            hold_frame_reg.right <= (cfg.channel_count == CH_MONO) ? left_conv
                                    : convert(s_right_raw, cfg.width_mode);
            hold_frame_reg.eos   <= s_end_of_stream;
        end
    end

endmodule

@@ sv/pcmn_fifo.sv @@
// Short frame queue between the front end and the rate converter.
// Depends on pcmn_pkg for depth and the frame type.
module pcmn_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  pcmn_pkg::frame_t push_frame,
    output logic             pop_valid,
    input  logic             pop_ready,
    output pcmn_pkg::frame_t pop_frame
);
    import pcmn_pkg::*;

    frame_t           mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_frame  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ sv/pcmn_back.sv @@
// Back end: phase-accumulator zero-order hold, an output a cycle unless stalled.
// Depends on pcmn_pkg; drains the frame queue into the output register.
module pcmn_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  pcmn_pkg::cfg_t     cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  pcmn_pkg::frame_t   pop_frame,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_left,
    output logic signed [15:0] m_out_right,
    output logic               m_last_of_run
);
    import pcmn_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [CNT_W-1:0] count_reg;
    logic [ACC_W-1:0] rate;
    logic [ACC_W-1:0] sum;
    logic             hit;
    logic             done;
    logic             advance;
    logic             m_valid_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic             last_reg;

    // Clamp the source rate to the supported range
    always_comb begin
        rate = ACC_W'(cfg.source_rate);
        if (rate < ACC_W'(MIN_RATE)) begin
            rate = ACC_W'(MIN_RATE);
        end
        if (rate > ACC_W'(TARGET_RATE)) begin
            rate = ACC_W'(TARGET_RATE);
        end
    end

    // Step the accumulator; end the run on wrap or when the run is full
    always_comb begin
        sum  = acc_reg + rate;
        hit  = (sum >= ACC_W'(TARGET_RATE));
        done = hit || (count_reg == CNT_W'(MAX_RESULTS - 1));
        if (pop_frame.eos || !hit) begin
            acc_next = '0;
        end else begin
            acc_next = sum - ACC_W'(TARGET_RATE);
        end
    end

    assign advance   = pop_valid && (!m_valid_reg || m_ready);
    assign pop_ready = advance && done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            count_reg <= '0;
        end else if (advance) begin
            if (done) begin
                acc_reg   <= acc_next;
                count_reg <= '0;
            end else begin
                acc_reg   <= sum;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg  <= pop_frame.left;
            right_reg <= pop_frame.right;
            last_reg  <= done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_left    = left_reg;
    assign m_out_right   = right_reg;
    assign m_last_of_run = last_reg;

endmodule
